>>> sv/pal_pkg.sv
// shared types and constants for the positional array list
package pal_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int POS_W        = 5;
  localparam int FOUND_W      = 4;
  localparam int COUNT_OUT_W  = 5;
  localparam int IN_DATA_W    = 40;
  localparam int OUT_DATA_W   = 48;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT     = 3'd4,
    ACT_ERASE      = 3'd5,
    ACT_SEARCH     = 3'd6,
    ACT_READ       = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_POS   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SH_NONE  = 2'd0,
    SH_OPEN  = 2'd1,
    SH_CLOSE = 2'd2
  } shift_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    shift_t               kind;
    logic [VALUE_W-1:0]   value;
  } cell_ctl_t;

endpackage

>>> sv/pal_cell.sv
// one storage cell of the list chain: hold, load, or take a neighbor's entry
module pal_cell #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  logic                         clk,
  input  pal_pkg::cell_ctl_t           ctl,
  input  logic [IW-1:0]                at,
  input  logic [IW-1:0]                count,
  input  logic [pal_pkg::VALUE_W-1:0]  left_q,
  input  logic [pal_pkg::VALUE_W-1:0]  right_q,
  output logic [pal_pkg::VALUE_W-1:0]  data_q,
  output logic                         match
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [pal_pkg::VALUE_W-1:0] data_r;
  logic [pal_pkg::VALUE_W-1:0] data_nxt;
  logic [IW:0]                 idx_plus1;

  assign idx_plus1 = {1'b0, MY_IDX} + {{IW{1'b0}}, 1'b1};

  always_comb begin
    data_nxt = data_r;
    case (ctl.kind)
      pal_pkg::SH_OPEN: begin
        if (MY_IDX == at) begin
          data_nxt = ctl.value;
        end else if (MY_IDX > at && MY_IDX <= count) begin
          data_nxt = left_q;
        end
      end
      pal_pkg::SH_CLOSE: begin
        // cells from the gap up to the one below the last move down
        if (MY_IDX >= at && idx_plus1 < {1'b0, count}) begin
          data_nxt = right_q;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign match  = (MY_IDX < count) && (data_r == ctl.value);

endmodule

>>> sv/positional_array_list.sv
// positional array list: ordered list of signed 32-bit entries in a chain of cells
//
// Usage: one request per input transfer on in_*, one result per request on out_*.
// A request is push back, pop back, push front, pop front, insert, erase, search
// or read; insert and erase move the later entries by one place in the same cycle
// because every cell takes its neighbor's entry in parallel.
// Output: the result is registered and appears in the cycle after the input
// transfer. Throughput: one request per cycle while out_tready is high; the list
// update, the compare of all cells for search and the position mux for read all
// finish in the cycle of the transfer. The list state is updated at the input
// transfer, so the result carries the count after the request.
// Stalls: in_tready is high while the result register is empty or being taken;
// when out_tready is low with a result waiting, input stops until it drains.
// Reset: rst_n (synchronous, active low) empties the list and the result register.
// Entry contents are not cleared; entries at or beyond the count are never read.
// Search gives the lowest matching index; found_index is 0 when nothing matches.
module positional_array_list #(
  parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // action[2:0], position[7:3], value[39:8]
  input  logic [pal_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[2:0], found_index[6:3], read_value[38:7], item_count[43:39], zero pad
  output logic [pal_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int CW = (IW > pal_pkg::POS_W) ? IW : pal_pkg::POS_W;
  localparam logic [IW-1:0] CAP_IW = IW'(CAPACITY);
  localparam int PAD_W = pal_pkg::OUT_DATA_W - 3 - pal_pkg::FOUND_W
                         - pal_pkg::VALUE_W - pal_pkg::COUNT_OUT_W;

  logic [IW-1:0]                count_r;
  logic [IW-1:0]                count_nxt;
  logic                         out_valid_r;
  logic [pal_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [pal_pkg::OUT_DATA_W-1:0] out_data_nxt;

  logic                         in_xfer;
  pal_pkg::action_t             act;
  logic [pal_pkg::POS_W-1:0]    pos;
  logic [pal_pkg::VALUE_W-1:0]  val;
  logic [CW-1:0]                pos_w;
  logic [CW-1:0]                cnt_w;
  logic                         full;
  logic                         empty;

  pal_pkg::cell_ctl_t           ctl;
  pal_pkg::shift_t              kind;
  logic [IW-1:0]                at;
  pal_pkg::status_t             status;
  logic [pal_pkg::VALUE_W-1:0]  rd_value;
  logic [pal_pkg::VALUE_W-1:0]  rd_mux;
  logic                         any_match;
  int                           found_int;
  logic [pal_pkg::FOUND_W-1:0]  found_out;

  logic [pal_pkg::VALUE_W-1:0]  cell_q [CAPACITY];
  logic [CAPACITY-1:0]          cell_match;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  assign act   = pal_pkg::action_t'(in_tdata[2:0]);
  assign pos   = in_tdata[7:3];
  assign val   = in_tdata[39:8];
  assign pos_w = CW'(pos);
  assign cnt_w = CW'(count_r);
  assign full  = (count_r == CAP_IW);
  assign empty = (count_r == '0);

  // read mux and first-match encoder over the cell outputs
  always_comb begin
    rd_mux    = '0;
    any_match = 1'b0;
    found_int = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (pos_w == CW'(i)) begin
        rd_mux = cell_q[i];
      end
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        any_match = 1'b1;
        found_int = i;
      end
    end
  end

  always_comb begin
    kind      = pal_pkg::SH_NONE;
    at        = '0;
    status    = pal_pkg::ST_OK;
    rd_value  = '0;
    found_out = '0;
    count_nxt = count_r;
    case (act)
      pal_pkg::ACT_PUSH_BACK: begin
        if (full) begin
          status = pal_pkg::ST_FULL;
        end else begin
          kind = pal_pkg::SH_OPEN;
          at   = count_r;
          count_nxt = count_r + IW'(1);
        end
      end
      pal_pkg::ACT_POP_BACK: begin
        if (empty) begin
          status = pal_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - IW'(1);
        end
      end
      pal_pkg::ACT_PUSH_FRONT: begin
        if (full) begin
          status = pal_pkg::ST_FULL;
        end else begin
          kind = pal_pkg::SH_OPEN;
          count_nxt = count_r + IW'(1);
        end
      end
      pal_pkg::ACT_POP_FRONT: begin
        if (empty) begin
          status = pal_pkg::ST_EMPTY;
        end else begin
          kind = pal_pkg::SH_CLOSE;
          count_nxt = count_r - IW'(1);
        end
      end
      pal_pkg::ACT_INSERT: begin
        if (pos_w > cnt_w) begin
          status = pal_pkg::ST_BAD_POS;
        end else if (full) begin
          status = pal_pkg::ST_FULL;
        end else begin
          kind = pal_pkg::SH_OPEN;
          at   = IW'(pos_w);
          count_nxt = count_r + IW'(1);
        end
      end
      pal_pkg::ACT_ERASE: begin
        if (pos_w >= cnt_w) begin
          status = pal_pkg::ST_BAD_POS;
        end else begin
          kind = pal_pkg::SH_CLOSE;
          at   = IW'(pos_w);
          count_nxt = count_r - IW'(1);
        end
      end
      pal_pkg::ACT_SEARCH: begin
        if (any_match) begin
          found_out = pal_pkg::FOUND_W'(found_int);
        end else begin
          status = pal_pkg::ST_NOT_FOUND;
        end
      end
      pal_pkg::ACT_READ: begin
        if (pos_w >= cnt_w) begin
          status = pal_pkg::ST_BAD_POS;
        end else begin
          rd_value = rd_mux;
        end
      end
      default: begin
        status = pal_pkg::ST_OK;
      end
    endcase
  end

  assign ctl.kind  = in_xfer ? kind : pal_pkg::SH_NONE;
  assign ctl.value = val;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [pal_pkg::VALUE_W-1:0] left_q;
      logic [pal_pkg::VALUE_W-1:0] right_q;
      if (g == 0) begin : g_first
        assign left_q = '0;
      end else begin : g_mid_l
        assign left_q = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_q = '0;
      end else begin : g_mid_r
        assign right_q = cell_q[g+1];
      end
      pal_cell #(
        .IDX (g),
        .IW  (IW)
      ) u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .at      (at),
        .count   (count_r),
        .left_q  (left_q),
        .right_q (right_q),
        .data_q  (cell_q[g]),
        .match   (cell_match[g])
      );
    end
  endgenerate

  assign out_data_nxt = {{PAD_W{1'b0}},
                         pal_pkg::COUNT_OUT_W'(CW'(count_nxt)),
                         rd_value,
                         found_out,
                         status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        count_r <= count_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_IW)
    else $error("list count above capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2:0] == pal_pkg::ST_FULL |->
      out_data_r[43:39] == pal_pkg::COUNT_OUT_W'(CW'(CAP_IW)))
    else $error("full status with list not at capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2:0] == pal_pkg::ST_EMPTY |->
      out_data_r[43:39] == '0)
    else $error("empty status with entries present");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("request without a result");

endmodule
